FILE: rtl/core/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, register codes and defaults of the hysteresis trigger pulse
// sequencer.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int CHANNELS_DEF    = 12;
    localparam int QUEUE_DEPTH_DEF = 12;
    localparam int CMD_FIFO_DEPTH  = 2;

    localparam int CH_W     = 4;
    localparam int LEVELS_W = 12;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CHANNEL = 3'd4;

    localparam logic [7:0]      ON_THRESHOLD_RST  = 8'd110;
    localparam logic [7:0]      OFF_THRESHOLD_RST = 8'd90;
    localparam logic [7:0]      CONFIRM_COUNT_RST = 8'd2;
    localparam logic [15:0]     PULSE_LENGTH_RST  = 16'd150;
    localparam logic [CH_W-1:0] LEVEL_CHANNEL_RST = 4'd11;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic            opcode;
        logic [CH_W-1:0] channel_index;
        logic [7:0]      sample_value;
    } in_item_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] output_levels;
        logic                pulse_active;
        logic [CH_W-1:0]     pulse_channel;
        logic [COUNT_W-1:0]  queue_count;
        logic                dropped;
    } out_item_t;

    typedef struct packed {
        logic [7:0]      on_threshold;
        logic [7:0]      off_threshold;
        logic [7:0]      confirm_count;
        logic [15:0]     pulse_length;
        logic [CH_W-1:0] level_channel;
    } cfg_t;

    typedef struct packed {
        logic            is_tick;
        logic            push_req;
        logic            level_set;
        logic            level_clr;
        logic [CH_W-1:0] channel;
    } cmd_t;

endpackage

FILE: rtl/core/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front
// Per-channel hysteresis: confirm counters and on/off state. Turns each item
// into a command for the back end.
// ----------------------------------------------------------------------------
module hts_front #(
    parameter int CHANNELS = hts_pkg::CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  hts_pkg::in_item_t in_item,
    input  hts_pkg::cfg_t     cfg,
    output hts_pkg::cmd_t     cmd
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]          above_reg [CHANNELS];
    logic [7:0]          below_reg [CHANNELS];
    logic [CHANNELS-1:0] channel_on_reg;

    logic [CH_IDX_W-1:0] idx;
    logic [7:0]          above_next;
    logic [7:0]          below_next;
    logic                on_next;
    logic                turn_on;
    logic                turn_off;
    logic                in_range;
    logic                is_level;
    logic                upd;

    assign idx      = in_item.channel_index[CH_IDX_W-1:0];
    assign in_range = {1'b0, in_item.channel_index} < 5'(CHANNELS);
    assign is_level = in_item.channel_index == cfg.level_channel;
    assign upd      = accept && (in_item.opcode == hts_pkg::OP_SAMPLE) && in_range;

    always_comb
    begin
        above_next = above_reg[idx];
        below_next = below_reg[idx];
        on_next    = channel_on_reg[idx];
        turn_on    = 1'b0;
        turn_off   = 1'b0;
        if (in_item.sample_value >= cfg.on_threshold)
        begin
            if (above_next < cfg.confirm_count)
            begin
                above_next = above_next + 8'd1;
            end
            below_next = '0;
        end
        else if (in_item.sample_value <= cfg.off_threshold)
        begin
            if (below_next < cfg.confirm_count)
            begin
                below_next = below_next + 8'd1;
            end
            above_next = '0;
        end
        if (!channel_on_reg[idx] && above_next >= cfg.confirm_count)
        begin
            turn_on    = 1'b1;
            on_next    = 1'b1;
            above_next = '0;
        end
        else if (channel_on_reg[idx] && below_next >= cfg.confirm_count)
        begin
            turn_off   = 1'b1;
            on_next    = 1'b0;
            below_next = '0;
        end
    end

    always_comb
    begin
        cmd.is_tick   = in_item.opcode == hts_pkg::OP_TICK;
        cmd.push_req  = (in_item.opcode == hts_pkg::OP_SAMPLE) && in_range && turn_on && !is_level;
        cmd.level_set = (in_item.opcode == hts_pkg::OP_SAMPLE) && in_range && turn_on && is_level;
        cmd.level_clr = (in_item.opcode == hts_pkg::OP_SAMPLE) && in_range && turn_off && is_level;
        cmd.channel   = in_item.channel_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_on_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                above_reg[i] <= '0;
                below_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            channel_on_reg[idx] <= on_next;
            above_reg[idx]      <= above_next;
            below_reg[idx]      <= below_next;
        end
    end

endmodule

FILE: rtl/core/hts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hts_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module hts_cmd_fifo #(
    parameter int DEPTH = hts_pkg::CMD_FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hts_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output hts_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hts_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back
// Pulse queue, pulse timer and output pins. Registers one result per command.
// ----------------------------------------------------------------------------
module hts_back #(
    parameter int CHANNELS    = hts_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hts_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  hts_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output hts_pkg::out_item_t out_item
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

    logic [hts_pkg::CH_W-1:0] pend_queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic                     busy_reg, busy_next;
    logic [hts_pkg::CH_W-1:0] owner_reg, owner_next;
    logic [15:0]              ticks_reg, ticks_next;
    logic [CHANNELS-1:0]      drive_reg, drive_next;
    logic                     out_valid_reg;
    hts_pkg::out_item_t       out_item_reg, out_item_next;

    logic                     q_wr;
    logic                     drop;
    logic [15:0]              ticks_dec;
    logic [hts_pkg::CH_W-1:0] head_ch;
    logic [15:0]              levels_wide;
    logic [7:0]               fill_wide;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign head_ch   = pend_queue_reg[head_reg];
    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - 16'd1 : ticks_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        busy_next  = busy_reg;
        owner_next = owner_reg;
        ticks_next = ticks_reg;
        drive_next = drive_reg;
        q_wr       = 1'b0;
        drop       = 1'b0;
        if (cmd.is_tick)
        begin
            if (busy_reg)
            begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    drive_next[owner_reg[CH_IDX_W-1:0]] = 1'b0;
                    busy_next  = 1'b0;
                    owner_next = '0;
                end
            end
            if (!busy_next && fill_reg != '0)
            begin
                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_next  = fill_reg - 1'b1;
                drive_next[head_ch[CH_IDX_W-1:0]] = 1'b1;
                busy_next  = 1'b1;
                owner_next = head_ch;
                ticks_next = cfg.pulse_length;
            end
        end
        else
        begin
            if (cmd.level_set)
            begin
                drive_next[cmd.channel[CH_IDX_W-1:0]] = 1'b1;
            end
            if (cmd.level_clr)
            begin
                drive_next[cmd.channel[CH_IDX_W-1:0]] = 1'b0;
            end
            if (cmd.push_req)
            begin
                if (fill_reg == FILL_W'(QUEUE_DEPTH))
                begin
                    drop = 1'b1;
                end
                else
                begin
                    q_wr      = 1'b1;
                    tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        levels_wide = '0;
        levels_wide[CHANNELS-1:0] = drive_next;
        fill_wide = '0;
        fill_wide[FILL_W-1:0] = fill_next;
        out_item_next.output_levels = levels_wide[hts_pkg::LEVELS_W-1:0];
        out_item_next.pulse_active  = busy_next;
        out_item_next.pulse_channel = busy_next ? owner_next : '0;
        out_item_next.queue_count   = fill_wide[hts_pkg::COUNT_W-1:0];
        out_item_next.dropped       = drop;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && q_wr)
        begin
            pend_queue_reg[tail_reg] <= cmd.channel;
        end
        if (cmd_pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            ticks_reg     <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
                busy_reg  <= busy_next;
                owner_reg <= owner_next;
                ticks_reg <= ticks_next;
                drive_reg <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/hysteresis_trigger_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// hysteresis_trigger_pulse_sequencer
// Hysteresis trigger per channel feeding a queued, timed pulse sequencer.
// ----------------------------------------------------------------------------
//   channel  direction  signals                          item accepted when
//   in       input      in_valid, in_stall, in_item      in_valid && !in_stall
//   out      output     out_valid, out_stall, out_item   out_valid && !out_stall
//   cfg      input      cfg_wr_en, cfg_index, cfg_data   cfg_wr_en
//
// One item per cycle sustained while out_stall is low; each accepted item
// goes through the front update into a 2-entry command queue, then through
// the back end step into the output register, from which the result is taken.
// Reset clears channel state, pulse queue pointers and timer, loads register
// defaults; no clearing pass.
// out_stall holds the output register and the back end; in_stall rises once
// the command queue is full.
// ----------------------------------------------------------------------------
module hysteresis_trigger_pulse_sequencer #(
    parameter int CHANNELS    = hts_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  hts_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output hts_pkg::out_item_t               out_item,
    input  logic                             cfg_wr_en,
    input  logic [hts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hts_pkg::cfg_t cfg_reg;
    hts_pkg::cmd_t front_cmd;
    hts_pkg::cmd_t back_cmd;
    logic          accept;
    logic          fifo_full;
    logic          cmd_valid;
    logic          cmd_pop;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold  <= hts_pkg::ON_THRESHOLD_RST;
            cfg_reg.off_threshold <= hts_pkg::OFF_THRESHOLD_RST;
            cfg_reg.confirm_count <= hts_pkg::CONFIRM_COUNT_RST;
            cfg_reg.pulse_length  <= hts_pkg::PULSE_LENGTH_RST;
            cfg_reg.level_channel <= hts_pkg::LEVEL_CHANNEL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hts_pkg::CFG_ON_THRESHOLD:  cfg_reg.on_threshold  <= cfg_data[7:0];
                hts_pkg::CFG_OFF_THRESHOLD: cfg_reg.off_threshold <= cfg_data[7:0];
                hts_pkg::CFG_CONFIRM_COUNT: cfg_reg.confirm_count <= cfg_data[7:0];
                hts_pkg::CFG_PULSE_LENGTH:  cfg_reg.pulse_length  <= cfg_data;
                hts_pkg::CFG_LEVEL_CHANNEL: cfg_reg.level_channel <= cfg_data[hts_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    hts_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .cmd     (front_cmd)
    );

    hts_cmd_fifo #(
        .DEPTH (hts_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .pop_cmd   (back_cmd)
    );

    hts_back #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/core/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hts_checker #(
    parameter int CHANNELS    = hts_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input hts_pkg::out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_idle_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.pulse_active |-> out_item.pulse_channel == '0)
        else $error("pulse channel set with no pulse");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.pulse_active |-> out_item.pulse_channel < CHANNELS)
        else $error("pulse on nonexistent channel");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.dropped
            |-> (QUEUE_DEPTH >= 16) || (out_item.queue_count == QUEUE_DEPTH))
        else $error("request dropped with room in queue");

endmodule

bind hysteresis_trigger_pulse_sequencer hts_checker #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_hts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
